// ===== sv/ir_remote_pulse_distance_decoder_assert.svh =====
// assertion macros for the ir remote pulse distance decoder
// no dependencies; define ASSERT_OFF to drop every check
`ifndef IR_REMOTE_PULSE_DISTANCE_DECODER_ASSERT_SVH
`define IR_REMOTE_PULSE_DISTANCE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// property sampled on the rising clock edge, ignored while reset is low
`define IRPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("irpd assertion failed");

// plain invariant on the current state
`define IRPD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("irpd invariant failed");

`else

`define IRPD_ASSERT(label, clk, rst_n, prop)
`define IRPD_ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

// ===== sv/irpd_pkg.sv =====
// shared constants, types and register indexes for the ir remote decoder
// no dependencies

package irpd_pkg;

    localparam int TS_W              = 17;
    localparam int INTV_W            = TS_W + 1;
    localparam int WRAP_PERIOD       = 70000;
    localparam int HOLDOFF_TICKS     = 4;
    localparam int FRAME_MEASUREMENTS = 33;
    localparam int CODE_BITS         = 32;
    localparam int CODE_W            = 32;
    localparam int BIT_IDX_W         = $clog2(CODE_W);
    localparam int POS_W             = 6;
    localparam int CNT_W             = 6;
    localparam int TICK_W            = 3;
    localparam int CFG_IDX_W         = 3;

    localparam logic [POS_W-1:0] POS_RESET = POS_W'(CODE_BITS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MAX = 3'd7;

    typedef struct packed {
        logic [TS_W-1:0] zero_min;
        logic [TS_W-1:0] zero_max;
        logic [TS_W-1:0] one_min;
        logic [TS_W-1:0] one_max;
        logic [TS_W-1:0] repeat_min;
        logic [TS_W-1:0] repeat_max;
        logic [TS_W-1:0] header_min;
        logic [TS_W-1:0] header_max;
    } limits_t;

    localparam limits_t LIMITS_RESET = '{
        zero_min:   17'd500,
        zero_max:   17'd590,
        one_min:    17'd1600,
        one_max:    17'd1770,
        repeat_min: 17'd2150,
        repeat_max: 17'd2475,
        header_min: 17'd4200,
        header_max: 17'd4950
    };

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_ZERO,
        CLS_ONE,
        CLS_REPEAT,
        CLS_HEADER
    } class_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_FALL = 3'b010,
        PH_RISE = 3'b100
    } phase_t;

endpackage

// ===== sv/irpd_classify.sv =====
// sorts a measured high interval into zero, one, repeat header or frame header
// depends on irpd_pkg

module irpd_classify (
    input  irpd_pkg::limits_t                 limits,
    input  logic [irpd_pkg::INTV_W-1:0]       intv,
    input  logic                              intv_ovf,
    output irpd_pkg::class_t                  cls
);

    logic is_zero;
    logic is_one;
    logic is_repeat;
    logic is_header;

    assign is_zero   = !intv_ovf && intv <= irpd_pkg::INTV_W'(limits.zero_max)
                       && intv >= irpd_pkg::INTV_W'(limits.zero_min);
    assign is_one    = !intv_ovf && intv <= irpd_pkg::INTV_W'(limits.one_max)
                       && intv >= irpd_pkg::INTV_W'(limits.one_min);
    assign is_repeat = !intv_ovf && intv <= irpd_pkg::INTV_W'(limits.repeat_max)
                       && intv > irpd_pkg::INTV_W'(limits.repeat_min);
    assign is_header = !intv_ovf && intv <= irpd_pkg::INTV_W'(limits.header_max)
                       && intv > irpd_pkg::INTV_W'(limits.header_min);

    // priority: zero, one, repeat, header
    always_comb begin
        if (is_zero) begin
            cls = irpd_pkg::CLS_ZERO;
        end else if (is_one) begin
            cls = irpd_pkg::CLS_ONE;
        end else if (is_repeat) begin
            cls = irpd_pkg::CLS_REPEAT;
        end else if (is_header) begin
            cls = irpd_pkg::CLS_HEADER;
        end else begin
            cls = irpd_pkg::CLS_NONE;
        end
    end

endmodule

// ===== sv/ir_remote_pulse_distance_decoder.sv =====
// ir remote pulse distance decoder: edge and tick events in, one status result per event
// path: an input transfer passes the input register, then the decoder state register, before its result is offered
// throughput: one item per cycle while m_ready accepts results; the input register refills while the result is taken
// reset: aresetn synchronous active low; clears decoder state and restores the default limits
// depends on irpd_pkg, irpd_classify and ir_remote_pulse_distance_decoder_assert.svh

`include "ir_remote_pulse_distance_decoder_assert.svh"

module ir_remote_pulse_distance_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic                                s_level,
    input  logic [irpd_pkg::TS_W-1:0]           s_timestamp,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [irpd_pkg::CODE_W-1:0]         m_last_code,
    output logic                                m_code_updated,
    output logic                                m_repeat_seen,
    output logic                                m_holdoff_active,
    input  logic                                cfg_wr_en,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irpd_pkg::TS_W-1:0]           cfg_wr_data
);

    irpd_pkg::limits_t                  limits_reg;

    logic                               in_valid_reg;
    logic                               in_cmd_reg;
    logic                               in_level_reg;
    logic [irpd_pkg::TS_W-1:0]          in_ts_reg;

    logic                               out_valid_reg;
    logic                               updated_reg, updated_next;
    logic [irpd_pkg::CODE_W-1:0]        shift_word_reg, shift_word_next;
    logic [irpd_pkg::POS_W-1:0]         bit_pos_reg, bit_pos_next;
    logic [irpd_pkg::CNT_W-1:0]         meas_cnt_reg, meas_cnt_next;
    logic                               repeat_reg, repeat_next;
    irpd_pkg::phase_t                   phase_reg, phase_next;
    logic [irpd_pkg::TS_W-1:0]          rise_time_reg, rise_time_next;
    logic [irpd_pkg::CODE_W-1:0]        published_reg, published_next;
    logic                               holdoff_reg, holdoff_next;
    logic [irpd_pkg::TICK_W-1:0]        ticks_reg, ticks_next;

    logic                               advance;
    logic [irpd_pkg::INTV_W-1:0]        wrap_sum;
    logic [irpd_pkg::INTV_W:0]          wrap_diff;
    logic [irpd_pkg::INTV_W-1:0]        intv;
    logic                               intv_ovf;
    logic [irpd_pkg::TICK_W-1:0]        ticks_inc;
    irpd_pkg::class_t                   cls;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg <= irpd_pkg::LIMITS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                irpd_pkg::REG_ZERO_MIN:   limits_reg.zero_min   <= cfg_wr_data;
                irpd_pkg::REG_ZERO_MAX:   limits_reg.zero_max   <= cfg_wr_data;
                irpd_pkg::REG_ONE_MIN:    limits_reg.one_min    <= cfg_wr_data;
                irpd_pkg::REG_ONE_MAX:    limits_reg.one_max    <= cfg_wr_data;
                irpd_pkg::REG_REPEAT_MIN: limits_reg.repeat_min <= cfg_wr_data;
                irpd_pkg::REG_REPEAT_MAX: limits_reg.repeat_max <= cfg_wr_data;
                irpd_pkg::REG_HEADER_MIN: limits_reg.header_min <= cfg_wr_data;
                irpd_pkg::REG_HEADER_MAX: limits_reg.header_max <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg   <= s_cmd;
            in_level_reg <= s_level;
            in_ts_reg    <= s_timestamp;
        end
    end

    // high interval, wrap period added when the timer has not moved forward
    assign wrap_sum  = irpd_pkg::INTV_W'(in_ts_reg) + irpd_pkg::INTV_W'(irpd_pkg::WRAP_PERIOD);
    assign wrap_diff = {1'b0, wrap_sum} - (irpd_pkg::INTV_W + 1)'(rise_time_reg);

    always_comb begin
        if (in_ts_reg > rise_time_reg) begin
            intv     = irpd_pkg::INTV_W'(in_ts_reg) - irpd_pkg::INTV_W'(rise_time_reg);
            intv_ovf = 1'b0;
        end else begin
            intv     = wrap_diff[irpd_pkg::INTV_W-1:0];
            intv_ovf = wrap_diff[irpd_pkg::INTV_W];
        end
    end

    irpd_classify u_classify (
        .limits   (limits_reg),
        .intv     (intv),
        .intv_ovf (intv_ovf),
        .cls      (cls)
    );

    assign ticks_inc = ticks_reg + irpd_pkg::TICK_W'(1);

    always_comb begin
        updated_next    = updated_reg;
        shift_word_next = shift_word_reg;
        bit_pos_next    = bit_pos_reg;
        meas_cnt_next   = meas_cnt_reg;
        repeat_next     = repeat_reg;
        phase_next      = phase_reg;
        rise_time_next  = rise_time_reg;
        published_next  = published_reg;
        holdoff_next    = holdoff_reg;
        ticks_next      = ticks_reg;

        if (advance) begin
            updated_next = 1'b0;
            if (in_cmd_reg == irpd_pkg::CMD_EDGE) begin
                if (!holdoff_reg) begin
                    // frame complete: publish on this edge unless a repeat was seen, then handle the edge itself
                    if (meas_cnt_reg > irpd_pkg::CNT_W'(irpd_pkg::FRAME_MEASUREMENTS)) begin
                        bit_pos_next  = irpd_pkg::POS_RESET;
                        meas_cnt_next = '0;
                        if (!repeat_reg) begin
                            published_next = shift_word_reg;
                            updated_next   = 1'b1;
                        end
                        shift_word_next = '0;
                        holdoff_next    = 1'b1;
                        ticks_next      = '0;
                    end
                    if (in_level_reg) begin
                        rise_time_next = in_ts_reg;
                        phase_next     = irpd_pkg::PH_RISE;
                    end else begin
                        unique case (phase_reg)
                            irpd_pkg::PH_IDLE: phase_next = irpd_pkg::PH_FALL;
                            irpd_pkg::PH_FALL: phase_next = irpd_pkg::PH_FALL;
                            irpd_pkg::PH_RISE: begin
                                if (meas_cnt_next != irpd_pkg::CNT_MAX) begin
                                    meas_cnt_next = meas_cnt_next + irpd_pkg::CNT_W'(1);
                                end
                                unique case (cls) inside
                                    irpd_pkg::CLS_ZERO, irpd_pkg::CLS_ONE: begin
                                        // negative position: bits past zero are dropped
                                        if (!bit_pos_next[irpd_pkg::POS_W-1]) begin
                                            shift_word_next[bit_pos_next[irpd_pkg::BIT_IDX_W-1:0]] =
                                                (cls == irpd_pkg::CLS_ONE);
                                            bit_pos_next = bit_pos_next - irpd_pkg::POS_W'(1);
                                        end
                                    end
                                    irpd_pkg::CLS_REPEAT: repeat_next = 1'b1;
                                    irpd_pkg::CLS_HEADER: begin
                                        repeat_next  = 1'b0;
                                        bit_pos_next = irpd_pkg::POS_RESET;
                                    end
                                    default: ;
                                endcase
                                phase_next     = irpd_pkg::PH_IDLE;
                                rise_time_next = '0;
                            end
                            default: phase_next = irpd_pkg::PH_IDLE;
                        endcase
                    end
                end
            end else if (holdoff_reg) begin
                if (ticks_inc >= irpd_pkg::TICK_W'(irpd_pkg::HOLDOFF_TICKS)) begin
                    holdoff_next = 1'b0;
                    ticks_next   = '0;
                end else begin
                    ticks_next = ticks_inc;
                end
            end
        end
    end

    // decoder state doubles as the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            updated_reg    <= 1'b0;
            shift_word_reg <= '0;
            bit_pos_reg    <= irpd_pkg::POS_RESET;
            meas_cnt_reg   <= '0;
            repeat_reg     <= 1'b0;
            phase_reg      <= irpd_pkg::PH_IDLE;
            rise_time_reg  <= '0;
            published_reg  <= '0;
            holdoff_reg    <= 1'b0;
            ticks_reg      <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            updated_reg    <= updated_next;
            shift_word_reg <= shift_word_next;
            bit_pos_reg    <= bit_pos_next;
            meas_cnt_reg   <= meas_cnt_next;
            repeat_reg     <= repeat_next;
            phase_reg      <= phase_next;
            rise_time_reg  <= rise_time_next;
            published_reg  <= published_next;
            holdoff_reg    <= holdoff_next;
            ticks_reg      <= ticks_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_last_code      = published_reg;
    assign m_code_updated   = updated_reg;
    assign m_repeat_seen    = repeat_reg;
    assign m_holdoff_active = holdoff_reg;

    `IRPD_ASSERT(a_publish_starts_holdoff, aclk, aresetn, m_valid && m_code_updated |-> m_holdoff_active)
    `IRPD_ASSERT_ALWAYS(a_ticks_idle_clear, aclk, aresetn, holdoff_reg || ticks_reg == '0)
    `IRPD_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, meas_cnt_reg <= irpd_pkg::CNT_W'(irpd_pkg::FRAME_MEASUREMENTS + 1))
    `IRPD_ASSERT(a_stalled_item_kept, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg)

endmodule
